/* src/wpd_pkg.sv */
// Shared types and constants for the waveform peak decimator.
// No dependencies; imported by every module of the block.
package wpd_pkg;

	localparam int FRAME_BITS_DEF  = 24;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int COL_BITS   = 16;
	localparam int GRID_BITS  = 24;
	localparam int ROW_BITS   = 13;
	localparam int VIEW_BITS  = 12;
	localparam int HALF_BITS  = VIEW_BITS - 1;
	localparam int RATIO_BITS = 32;

	localparam logic [RATIO_BITS-1:0] RATIO_ONE = 32'h0001_0000;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_RATIO    = 3'd0,
		REG_COLUMNS  = 3'd1,
		REG_VIEW_TOP = 3'd2,
		REG_VIEW_HT  = 3'd3,
		REG_GRID     = 3'd4,
		REG_STEREO   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		KIND_COLUMN = 1'b0,
		KIND_GRID   = 1'b1
	} kind_t;

	typedef struct packed {
		logic [RATIO_BITS-1:0] frames_per_pixel;
		logic [COL_BITS-1:0]   column_count;
		logic [VIEW_BITS-1:0]  view_top;
		logic [VIEW_BITS-1:0]  view_height;
		logic [GRID_BITS-1:0]  grid_interval;
		logic                  stereo;
	} cfg_t;

	// control part of one queued request; the two peaks follow it in the queue word
	typedef struct packed {
		logic                 grid_hit;
		logic                 col_close;
		logic [COL_BITS-1:0]  column;
		logic [GRID_BITS-1:0] grid_frame;
	} entry_ctl_t;

	localparam int CTL_W = $bits(entry_ctl_t);

endpackage

/* src/waveform_peak_decimator.sv */
// Top level of the waveform peak decimator: register file, front, queue, back.
// Depends on wpd_pkg, wpd_front, wpd_queue and wpd_back.
//
//   channel   direction  handshake                      payload
//   frame     in         frame_valid / frame_ready      sample_left, sample_right, end_of_wave
//   result    out        result_valid / result_ready    kind, column_index, top_row,
//                                                       bottom_row, grid_frame, run_last
//   apb       in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One frame per cycle is accepted while the request queue has room.
// A frame that closes a column yields its result through the queue, the multiply stage
// and the output register; the output register sends one result per cycle while result_ready
// does not stall it, so a frame with a grid marker and a column close sends two results, grid first.
// A stalled output backs up through the four-entry queue before frame_ready drops.
// Reset clears all counters and loads default register values; no clearing pass.
module waveform_peak_decimator import wpd_pkg::*; #(
	parameter int FRAME_BITS  = FRAME_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	input  logic                          frame_valid,
	output logic                          frame_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_left,
	input  logic signed [SAMPLE_BITS-1:0] sample_right,
	input  logic                          end_of_wave,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          kind,
	output logic [COL_BITS-1:0]           column_index,
	output logic [ROW_BITS-1:0]           top_row,
	output logic [ROW_BITS-1:0]           bottom_row,
	output logic [GRID_BITS-1:0]          grid_frame,
	output logic                          run_last
);

	localparam int ENTRY_W = CTL_W + 2 * (SAMPLE_BITS + 1);

	cfg_t               cfg_q;
	reg_idx_t           idx;
	logic               wr_en;
	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               q_not_full;
	logic               pop;
	logic [ENTRY_W-1:0] head;
	logic               q_not_empty;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frames_per_pixel <= RATIO_ONE;
			cfg_q.column_count     <= COL_BITS'(1);
			cfg_q.view_top         <= '0;
			cfg_q.view_height      <= VIEW_BITS'(1);
			cfg_q.grid_interval    <= '0;
			cfg_q.stereo           <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				REG_RATIO:    cfg_q.frames_per_pixel <= pwdata[RATIO_BITS-1:0];
				REG_COLUMNS:  cfg_q.column_count     <= pwdata[COL_BITS-1:0];
				REG_VIEW_TOP: cfg_q.view_top         <= pwdata[VIEW_BITS-1:0];
				REG_VIEW_HT:  cfg_q.view_height      <= pwdata[VIEW_BITS-1:0];
				REG_GRID:     cfg_q.grid_interval    <= pwdata[GRID_BITS-1:0];
				REG_STEREO:   cfg_q.stereo           <= pwdata[0];
				default:      cfg_q                  <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RATIO:    prdata = DATA_W'(cfg_q.frames_per_pixel);
			REG_COLUMNS:  prdata = DATA_W'(cfg_q.column_count);
			REG_VIEW_TOP: prdata = DATA_W'(cfg_q.view_top);
			REG_VIEW_HT:  prdata = DATA_W'(cfg_q.view_height);
			REG_GRID:     prdata = DATA_W'(cfg_q.grid_interval);
			REG_STEREO:   prdata = DATA_W'(cfg_q.stereo);
			default:      prdata = '0;
		endcase
	end

	wpd_front #(
		.FRAME_BITS  (FRAME_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.end_of_wave  (end_of_wave),
		.push         (push),
		.push_data    (push_data),
		.q_not_full   (q_not_full)
	);

	wpd_queue #(
		.ENTRY_W (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.not_full  (q_not_full),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty)
	);

	wpd_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.q_not_empty  (q_not_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.column_index (column_index),
		.top_row      (top_row),
		.bottom_row   (bottom_row),
		.grid_frame   (grid_frame),
		.run_last     (run_last)
	);

endmodule

/* src/wpd_queue.sv */
// Small FIFO of pending requests between the front and back parts.
// Depends on wpd_pkg for its depth.
module wpd_queue import wpd_pkg::*; #(
	parameter int ENTRY_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [ENTRY_W-1:0] push_data,
	output logic               not_full,
	input  logic               pop,
	output logic [ENTRY_W-1:0] head,
	output logic               not_empty
);

	logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head      = mem_q[rd_q];
	assign not_full  = cnt_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;

endmodule

/* src/wpd_front.sv */
// Front part: accepts frames, tracks peaks, column boundary and grid countdown,
// and, while columns remain, queues a request per frame that closes a column or hits a grid line. Uses wpd_pkg.
module wpd_front import wpd_pkg::*; #(
	parameter int FRAME_BITS  = FRAME_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cfg_t                                    cfg,
	input  logic                                    frame_valid,
	output logic                                    frame_ready,
	input  logic signed [SAMPLE_BITS-1:0]           sample_left,
	input  logic signed [SAMPLE_BITS-1:0]           sample_right,
	input  logic                                    end_of_wave,
	output logic                                    push,
	output logic [CTL_W+2*(SAMPLE_BITS+1)-1:0]      push_data,
	input  logic                                    q_not_full
);

	localparam int PW = SAMPLE_BITS + 1;
	localparam int BW = FRAME_BITS + 16;

	logic [FRAME_BITS-1:0]  frame_q;
	logic [COL_BITS-1:0]    col_q;
	logic [BW-1:0]          bound_q;
	logic signed [PW-1:0]   peak_hi_q;
	logic signed [PW-1:0]   peak_lo_q;
	logic [GRID_BITS-1:0]   grid_cnt_q;

	logic                   accept;
	logic                   active;
	logic signed [PW-1:0]   avg;
	logic signed [PW-1:0]   hi_n;
	logic signed [PW-1:0]   lo_n;
	logic [RATIO_BITS-1:0]  ratio;
	logic [BW:0]            bound_sum;
	logic [BW-1:0]          bound_n;
	logic [FRAME_BITS:0]    k_inc;
	logic                   close;
	logic                   grid_on;
	logic                   hit;
	entry_ctl_t             ctl;

	assign frame_ready = q_not_full;
	assign accept      = frame_valid && frame_ready;
	assign active      = col_q < cfg.column_count;

	always_comb begin
		if (cfg.stereo) begin
			avg = {sample_left[SAMPLE_BITS-1], sample_left}
				+ {sample_right[SAMPLE_BITS-1], sample_right};
		end else begin
			avg = {sample_left, 1'b0};
		end
		hi_n = peak_hi_q;
		lo_n = peak_lo_q;
		if (avg > peak_hi_q) begin
			hi_n = avg;
		end else if (avg <= peak_lo_q) begin
			lo_n = avg;
		end
	end

	assign ratio     = (cfg.frames_per_pixel < RATIO_ONE) ? RATIO_ONE : cfg.frames_per_pixel;
	assign bound_sum = {1'b0, bound_q} + (BW+1)'(ratio);
	assign bound_n   = bound_sum[BW] ? {BW{1'b1}} : bound_sum[BW-1:0];
	assign k_inc     = {1'b0, frame_q} + 1'b1;
	assign close     = end_of_wave || (k_inc >= {1'b0, bound_q[BW-1:16]});
	assign grid_on   = cfg.grid_interval != '0;
	assign hit       = grid_on && (frame_q != '0) && (grid_cnt_q == '0);

	always_comb begin
		ctl.grid_hit   = hit;
		ctl.col_close  = close;
		ctl.column     = col_q;
		ctl.grid_frame = GRID_BITS'(frame_q);
	end

	assign push      = accept && active && (hit || close);
	assign push_data = {ctl, hi_n, lo_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q    <= '0;
			col_q      <= '0;
			bound_q    <= BW'(RATIO_ONE);
			peak_hi_q  <= '0;
			peak_lo_q  <= '0;
			grid_cnt_q <= '0;
		end else if (accept) begin
			if (end_of_wave) begin
				frame_q    <= '0;
				col_q      <= '0;
				bound_q    <= BW'(ratio);
				peak_hi_q  <= '0;
				peak_lo_q  <= '0;
				grid_cnt_q <= cfg.grid_interval;
			end else if (active) begin
				frame_q <= frame_q + 1'b1;
				if (grid_on) begin
					if (frame_q == '0 || grid_cnt_q == '0) begin
						grid_cnt_q <= cfg.grid_interval - 1'b1;
					end else begin
						grid_cnt_q <= grid_cnt_q - 1'b1;
					end
				end
				if (close) begin
					col_q     <= col_q + 1'b1;
					bound_q   <= bound_n;
					peak_hi_q <= '0;
					peak_lo_q <= '0;
				end else begin
					peak_hi_q <= hi_n;
					peak_lo_q <= lo_n;
				end
			end
		end
	end

endmodule

/* src/wpd_back.sv */
// Back part: scales queued peaks to screen rows and sends grid markers and
// column results one per cycle, when result_ready allows, through an output register. Uses wpd_pkg.
module wpd_back import wpd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cfg_t                               cfg,
	input  logic [CTL_W+2*(SAMPLE_BITS+1)-1:0] head,
	input  logic                               q_not_empty,
	output logic                               pop,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic                               kind,
	output logic [COL_BITS-1:0]                column_index,
	output logic [ROW_BITS-1:0]                top_row,
	output logic [ROW_BITS-1:0]                bottom_row,
	output logic [GRID_BITS-1:0]               grid_frame,
	output logic                               run_last
);

	localparam int PW  = SAMPLE_BITS + 1;
	localparam int PHW = SAMPLE_BITS + HALF_BITS;
	localparam int PLW = SAMPLE_BITS + 1 + HALF_BITS;

	entry_ctl_t              h_ctl;
	logic signed [PW-1:0]    h_hi;
	logic signed [PW-1:0]    h_lo;
	logic [HALF_BITS-1:0]    half;
	logic [PW-1:0]           mag_lo;
	logic [PHW-1:0]          prod_hi;
	logic [PLW-1:0]          prod_lo;

	logic                    valid_s1;
	logic                    grid_s1;
	logic                    colp_s1;
	logic [COL_BITS-1:0]     col_s1;
	logic [GRID_BITS-1:0]    gframe_s1;
	logic [PHW-1:0]          phi_s1;
	logic [PLW-1:0]          plo_s1;

	logic                    out_free;
	logic                    take;
	logic                    last;
	logic [PHW:0]            hi_round;
	logic [HALF_BITS:0]      off_hi;
	logic [HALF_BITS:0]      off_lo;
	logic signed [ROW_BITS:0] vt_s;
	logic signed [ROW_BITS:0] zero_s;
	logic signed [ROW_BITS:0] top_s;
	logic signed [ROW_BITS:0] bot_s;
	logic signed [ROW_BITS:0] lim_s;
	logic signed [ROW_BITS:0] top_c;
	logic signed [ROW_BITS:0] bot_c;

	logic                    valid_q;
	kind_t                   kind_q;
	logic [COL_BITS-1:0]     col_q;
	logic [ROW_BITS-1:0]     top_q;
	logic [ROW_BITS-1:0]     bot_q;
	logic [GRID_BITS-1:0]    gframe_q;
	logic                    last_q;

	assign h_ctl   = entry_ctl_t'(head[CTL_W+2*PW-1:2*PW]);
	assign h_hi    = head[2*PW-1:PW];
	assign h_lo    = head[PW-1:0];
	assign half    = cfg.view_height[VIEW_BITS-1:1];
	assign mag_lo  = '0 - h_lo;
	assign prod_hi = PHW'(h_hi[SAMPLE_BITS-1:0]) * PHW'(half);
	assign prod_lo = PLW'(mag_lo) * PLW'(half);

	assign out_free = !valid_q || result_ready;
	assign take     = valid_s1 && out_free;
	assign last     = take && (grid_s1 ? !colp_s1 : 1'b1);
	assign pop      = q_not_empty && (!valid_s1 || last);

	always_ff @(posedge clk) begin
		if (pop) begin
			col_s1    <= h_ctl.column;
			gframe_s1 <= h_ctl.grid_frame;
			phi_s1    <= prod_hi;
			plo_s1    <= prod_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			grid_s1  <= 1'b0;
			colp_s1  <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
			grid_s1  <= h_ctl.grid_hit;
			colp_s1  <= h_ctl.col_close;
		end else if (last) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			grid_s1 <= 1'b0;
		end
	end

	always_comb begin
		hi_round = {1'b0, phi_s1} + {{(HALF_BITS+1){1'b0}}, {SAMPLE_BITS{1'b1}}};
		off_hi   = hi_round[PHW:SAMPLE_BITS];
		off_lo   = plo_s1[PLW-1:SAMPLE_BITS];
		vt_s     = signed'({2'b00, cfg.view_top});
		zero_s   = vt_s + signed'({3'b000, half});
		top_s    = zero_s - signed'({2'b00, off_hi});
		bot_s    = zero_s + signed'({2'b00, off_lo});
		lim_s    = vt_s + signed'({2'b00, cfg.view_height}) - 14'sd1;
		if (lim_s < vt_s) begin
			lim_s = vt_s;
		end
		top_c = (top_s < vt_s) ? vt_s : top_s;
		bot_c = (bot_s > lim_s) ? lim_s : bot_s;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_q <= col_s1;
			if (grid_s1) begin
				kind_q   <= KIND_GRID;
				top_q    <= '0;
				bot_q    <= '0;
				gframe_q <= gframe_s1;
				last_q   <= !colp_s1;
			end else begin
				kind_q   <= KIND_COLUMN;
				top_q    <= top_c[ROW_BITS-1:0];
				bot_q    <= bot_c[ROW_BITS-1:0];
				gframe_q <= '0;
				last_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign column_index = col_q;
	assign top_row      = top_q;
	assign bottom_row   = bot_q;
	assign grid_frame   = gframe_q;
	assign run_last     = last_q;

endmodule
